FILE: src/sic_pkg.sv
package sic_pkg;

  localparam int MemBytes = 4096;
  localparam int MemAw = $clog2(MemBytes);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_ADDR = 2'd2;

  localparam logic [1:0] CC_NONE = 2'd0;
  localparam logic [1:0] CC_EQ   = 2'd1;
  localparam logic [1:0] CC_GT   = 2'd2;
  localparam logic [1:0] CC_LT   = 2'd3;

  localparam logic [7:0] OP_ADD  = 8'h18;
  localparam logic [7:0] OP_AND  = 8'h40;
  localparam logic [7:0] OP_COMP = 8'h28;
  localparam logic [7:0] OP_DIV  = 8'h24;
  localparam logic [7:0] OP_J    = 8'h3C;
  localparam logic [7:0] OP_JEQ  = 8'h30;
  localparam logic [7:0] OP_JGT  = 8'h34;
  localparam logic [7:0] OP_JLT  = 8'h38;
  localparam logic [7:0] OP_JSUB = 8'h48;
  localparam logic [7:0] OP_LDA  = 8'h00;
  localparam logic [7:0] OP_LDCH = 8'h50;
  localparam logic [7:0] OP_LDL  = 8'h08;
  localparam logic [7:0] OP_LDX  = 8'h04;
  localparam logic [7:0] OP_MUL  = 8'h20;
  localparam logic [7:0] OP_OR   = 8'h44;
  localparam logic [7:0] OP_RSUB = 8'h4C;
  localparam logic [7:0] OP_STA  = 8'h0C;
  localparam logic [7:0] OP_STCH = 8'h54;
  localparam logic [7:0] OP_STL  = 8'h14;
  localparam logic [7:0] OP_STSW = 8'hE8;
  localparam logic [7:0] OP_STX  = 8'h10;
  localparam logic [7:0] OP_SUB  = 8'h1C;
  localparam logic [7:0] OP_TD   = 8'hE0;
  localparam logic [7:0] OP_TIX  = 8'h2C;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [14:0] address;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pc;
    logic [23:0] acc;
    logic [23:0] index_reg;
    logic [23:0] link_reg;
    logic [1:0]  cond_code;
    logic        halted;
    logic [1:0]  fault;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       take_in;     // latch input item
    logic       do_start;    // reset regs, set pc
    logic       mem_rd;      // read byte at address chosen by addr_sel
    logic [1:0] addr_sel;    // 0 input address, 1 pc, 2 operand
    logic [1:0] byte_no;     // byte offset of access
    logic [1:0] rd_dst;      // 0 opcode, 1 operand hi, 2 operand lo, 3 value
    logic       mem_wr;      // store byte byte_no of store word
    logic       wr_in;       // store input data byte
    logic       chk_fetch;   // check pc range
    logic       chk_oper;    // check operand range
    logic       exec;        // commit simple instruction
    logic       mul_start;
    logic       div_start;
    logic       ar_commit;   // commit mul/div result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       range_ok;
    logic [7:0] opcode;
    logic       running;
    logic       ar_done;
    logic       div_zero;
  } sts_t;

  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_PC   = 2'd1;
  localparam logic [1:0] SEL_OPND = 2'd2;

  localparam logic [1:0] DST_OPC = 2'd0;
  localparam logic [1:0] DST_HI  = 2'd1;
  localparam logic [1:0] DST_LO  = 2'd2;
  localparam logic [1:0] DST_VAL = 2'd3;

  function automatic logic reads_word(input logic [7:0] op);
    return op == OP_ADD || op == OP_AND || op == OP_COMP || op == OP_DIV ||
           op == OP_LDA || op == OP_LDL || op == OP_LDX || op == OP_MUL ||
           op == OP_OR || op == OP_SUB || op == OP_TIX;
  endfunction

  function automatic logic stores_word(input logic [7:0] op);
    return op == OP_STA || op == OP_STL || op == OP_STSW || op == OP_STX;
  endfunction

endpackage

FILE: src/sic_ram.sv
module sic_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: src/sic_arith.sv
module sic_arith import sic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        mul_start,
  input  logic        div_start,
  input  logic [23:0] a,
  input  logic [23:0] b,
  output logic        done,
  output logic [23:0] result
);
  // shift-add multiply, restoring divide, one bit per cycle
  logic        busy, is_div, neg_q;
  logic [4:0]  cnt;
  logic [23:0] acc_r, mcand, quo, dvsr;
  logic [24:0] rem;
  logic [24:0] rem_sh;
  logic [23:0] a_abs, b_abs;

  assign a_abs = a[23] ? 24'(-a) : a;
  assign b_abs = b[23] ? 24'(-b) : b;
  assign rem_sh = {rem[23:0], quo[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (mul_start || div_start) begin
        busy <= 1'b1;
        cnt  <= 5'd24;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start || div_start) begin
      is_div <= div_start;
      neg_q  <= a[23] ^ b[23];
      acc_r  <= '0;
      mcand  <= a;
      quo    <= div_start ? a_abs : b;
      dvsr   <= b_abs;
      rem    <= '0;
    end else if (busy) begin
      if (is_div) begin
        if (rem_sh >= {1'b0, dvsr}) begin
          rem <= rem_sh - {1'b0, dvsr};
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[22:0], 1'b0};
        end
      end else begin
        // multiplier bits taken msb first
        acc_r <= {acc_r[22:0], 1'b0} + (quo[23] ? mcand : 24'd0);
        quo   <= {quo[22:0], 1'b0};
      end
    end
  end

  assign result = is_div ? (neg_q ? 24'(-quo) : quo) : acc_r;
endmodule

FILE: src/sic_datapath.sv
module sic_datapath import sic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr,
  input  logic [14:0] cfg_data,
  input  in_item_t  item,
  input  ctl_t      ctl,
  output sts_t      sts,
  output out_item_t state_out
);
  logic [14:0] load_base;
  logic [23:0] acc, xr, lr, pc;
  logic [1:0]  cc;
  logic        running;
  in_item_t    held;
  logic [7:0]  opc;
  logic [15:0] opnd;
  logic [23:0] val, ta, npc, st_word, ar_res;
  logic [1:0]  rd_dst_q;
  logic        rd_q;
  logic [7:0]  rdata, wdata;
  logic [23:0] base_addr, acc_addr;
  logic [24:0] off;
  logic [MemAw-1:0] ram_addr;
  logic        ar_done;
  logic        ok_r;
  logic [23:0] span;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= '0;
    end else if (cfg_wr) begin
      load_base <= cfg_data;
    end
  end

  assign ta  = opnd[15] ? 24'(opnd[14:0] + xr) : {9'd0, opnd[14:0]};
  assign npc = 24'(pc + 24'd3);

  // address of current access and its range check
  always_comb begin
    unique case (ctl.addr_sel)
      SEL_IN:   base_addr = {9'd0, held.address};
      SEL_PC:   base_addr = pc;
      default:  base_addr = ta;
    endcase
    off = {1'b0, base_addr} - {10'd0, load_base};
    acc_addr = 24'(off[23:0] + {22'd0, ctl.byte_no});
    unique case (ctl.addr_sel)
      SEL_IN:  span = 24'd1;
      SEL_PC:  span = 24'd3;
      default: span = (reads_word(opc) || stores_word(opc)) ? 24'd3 : 24'd1;
    endcase
  end

  always_comb begin
    ok_r = !off[24] && (off[23:0] <= 24'(MemBytes) - span);
  end

  assign ram_addr = acc_addr[MemAw-1:0];

  always_comb begin
    unique case (ctl.byte_no)
      2'd0:    wdata = st_word[23:16];
      2'd1:    wdata = st_word[15:8];
      default: wdata = st_word[7:0];
    endcase
    if (ctl.wr_in) wdata = held.data_byte;
    if (opc == OP_STCH && ctl.mem_wr) wdata = acc[7:0];
  end

  always_comb begin
    unique case (opc)
      OP_STL:  st_word = lr;
      OP_STSW: st_word = {22'd0, cc};
      OP_STX:  st_word = xr;
      default: st_word = acc;
    endcase
  end

  sic_ram #(.Width(8), .Depth(MemBytes)) u_ram (
    .clk  (clk),
    .we   (ctl.mem_wr || ctl.wr_in),
    .addr (ram_addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  sic_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .mul_start(ctl.mul_start),
    .div_start(ctl.div_start),
    .a        (acc),
    .b        (val),
    .done     (ar_done),
    .result   (ar_res)
  );

  // capture read data in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q <= 1'b0;
    end else begin
      rd_q <= ctl.mem_rd;
    end
    rd_dst_q <= ctl.rd_dst;
    if (ctl.take_in) begin
      held <= item;
      val  <= '0;
    end
    if (rd_q) begin
      unique case (rd_dst_q)
        DST_OPC: opc <= rdata;
        DST_HI:  opnd[15:8] <= rdata;
        DST_LO:  opnd[7:0] <= rdata;
        default: val <= {val[15:0], rdata};
      endcase
    end
  end

  function automatic logic [1:0] cmp(input logic [23:0] x, input logic [23:0] y);
    if ($signed(x) > $signed(y)) return CC_GT;
    if ($signed(x) < $signed(y)) return CC_LT;
    return CC_EQ;
  endfunction

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; xr <= '0; lr <= '0; pc <= '0; cc <= CC_NONE; running <= 1'b0;
    end else if (ctl.do_start) begin
      acc <= '0; xr <= '0; lr <= '0; cc <= CC_NONE;
      pc <= {9'd0, held.address};
      running <= 1'b1;
    end else if (ctl.ar_commit) begin
      acc <= ar_res;
      pc  <= npc;
    end else if (ctl.exec) begin
      pc <= npc;
      unique case (opc)
        OP_ADD:  acc <= 24'(acc + val);
        OP_AND:  acc <= acc & val;
        OP_COMP: cc <= cmp(acc, val);
        OP_J:    pc <= ta;
        OP_JEQ:  if (cc == CC_EQ) pc <= ta;
        OP_JGT:  if (cc == CC_GT) pc <= ta;
        OP_JLT:  if (cc == CC_LT) pc <= ta;
        OP_JSUB: begin lr <= npc; pc <= ta; end
        OP_LDA:  acc <= val;
        OP_LDCH: acc <= {acc[23:8], val[7:0]};
        OP_LDL:  lr <= val;
        OP_LDX:  xr <= val;
        OP_OR:   acc <= acc | val;
        OP_RSUB: begin
          if (lr == 24'd0) running <= 1'b0;
          else pc <= lr;
        end
        OP_SUB:  acc <= 24'(acc - val);
        OP_TD:   cc <= CC_GT;
        OP_TIX: begin
          xr <= 24'(xr + 24'd1);
          cc <= cmp(24'(xr + 24'd1), val);
        end
        default: ;
      endcase
    end
  end

  assign sts.range_ok = ok_r;
  assign sts.opcode   = opc;
  assign sts.running  = running;
  assign sts.ar_done  = ar_done;
  assign sts.div_zero = (val == 24'd0);

  assign state_out.pc        = pc;
  assign state_out.acc       = acc;
  assign state_out.index_reg = xr;
  assign state_out.link_reg  = lr;
  assign state_out.cond_code = cc;
  assign state_out.halted    = !running;
  assign state_out.fault     = FAULT_NONE;
endmodule

FILE: src/sic_ctrl.sv
module sic_ctrl import sic_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic [1:0] cmd,
  input  sts_t     sts,
  output ctl_t     ctl,
  output logic     busy,
  output logic     done,
  output logic [1:0] fault
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_FWAIT = 4'd3;
  localparam logic [3:0] S_OPER  = 4'd4;
  localparam logic [3:0] S_OWAIT = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_STORE = 4'd7;
  localparam logic [3:0] S_ARITH = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] cmd_q;
  logic [1:0] fault_next;
  logic [7:0] op;

  assign op = sts.opcode;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      fault <= FAULT_NONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      fault <= fault_next;
      done  <= (state_next == S_DONE);
    end
    if (start && !busy) cmd_q <= cmd;
  end

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    fault_next = fault;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.take_in = 1'b1;
          fault_next  = FAULT_NONE;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        ctl.addr_sel = SEL_IN;
        priority if (cmd_q == CMD_WRITE) begin
          if (sts.range_ok) ctl.wr_in = 1'b1;
          else fault_next = FAULT_ADDR;
          state_next = S_DONE;
        end else if (cmd_q == CMD_START) begin
          ctl.do_start = 1'b1;
          state_next = S_DONE;
        end else if (cmd_q == CMD_STEP && sts.running) begin
          cnt_next = 2'd0;
          state_next = S_FETCH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FETCH: begin
        ctl.addr_sel = SEL_PC;
        if (!sts.range_ok) begin
          fault_next = FAULT_ADDR;
          state_next = S_DONE;
        end else begin
          ctl.mem_rd  = 1'b1;
          ctl.byte_no = cnt;
          ctl.rd_dst  = (cnt == 2'd0) ? DST_OPC : (cnt == 2'd1) ? DST_HI : DST_LO;
          cnt_next    = 2'(cnt + 2'd1);
          if (cnt == 2'd2) state_next = S_FWAIT;
        end
      end
      S_FWAIT: begin
        cnt_next = 2'd0;
        state_next = S_OPER;
      end
      S_OPER: begin
        ctl.addr_sel = SEL_OPND;
        if (reads_word(op) || op == OP_LDCH || stores_word(op) || op == OP_STCH) begin
          if (!sts.range_ok) begin
            fault_next = FAULT_ADDR;
            state_next = S_DONE;
          end else if (stores_word(op) || op == OP_STCH) begin
            cnt_next = 2'd0;
            state_next = S_STORE;
          end else begin
            ctl.mem_rd  = 1'b1;
            ctl.byte_no = cnt;
            ctl.rd_dst  = DST_VAL;
            cnt_next    = 2'(cnt + 2'd1);
            if (op == OP_LDCH || cnt == 2'd2) state_next = S_OWAIT;
          end
        end else begin
          state_next = S_EXEC;
        end
      end
      S_OWAIT: state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_DIV && sts.div_zero) begin
          fault_next = FAULT_DIV0;
          state_next = S_DONE;
        end else if (op == OP_DIV) begin
          ctl.div_start = 1'b1;
          state_next = S_ARITH;
        end else if (op == OP_MUL) begin
          ctl.mul_start = 1'b1;
          state_next = S_ARITH;
        end else begin
          ctl.exec = 1'b1;
          state_next = S_DONE;
        end
      end
      S_STORE: begin
        ctl.addr_sel = SEL_OPND;
        ctl.mem_wr   = 1'b1;
        ctl.byte_no  = cnt;
        cnt_next     = 2'(cnt + 2'd1);
        if (op == OP_STCH || cnt == 2'd2) begin
          ctl.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_ARITH: begin
        if (sts.ar_done) begin
          ctl.ar_commit = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // a fault never comes with a register update
  assert property (@(posedge clk) disable iff (rst)
    (ctl.exec || ctl.ar_commit) |-> fault_next == FAULT_NONE)
    else $error("commit with fault");
  // memory writes only inside a command
  assert property (@(posedge clk) disable iff (rst)
    (ctl.mem_wr || ctl.wr_in) |-> busy)
    else $error("write while idle");
  // done lasts one cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
endmodule

FILE: src/sic_instruction_executor.sv
// SIC core with a 4096-byte memory. Pulse start with cmd/address/data_byte
// while busy is low; busy rises on the next edge and result_valid marks the
// single cycle in which result holds the registers after the item and its
// fault code. The receiver cannot stall. A byte write or start goes through
// dispatch and done; a step's length is set by the single-port memory doing
// one byte per cycle for fetch, operand and store, while MUL and DIV also
// wait for the one-bit-per-cycle arithmetic unit. load_base may be
// written through the cfg channel only while busy is low.
module sic_instruction_executor import sic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  output logic        result_valid,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);
  ctl_t      ctl;
  sts_t      sts;
  out_item_t st;
  logic [1:0] fault;

  assign cfg_ready = 1'b1;

  sic_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (item.cmd),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy),
    .done (result_valid),
    .fault(fault)
  );

  sic_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .item     (item),
    .ctl      (ctl),
    .sts      (sts),
    .state_out(st)
  );

  // result merges register state with fault code
  always_comb begin
    result = st;
    result.fault = fault;
  end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sic_pkg::*;

  localparam int WinBytes = 48;
  localparam int StallLimit = 5000;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [7:0] OP_RD = 8'hD8;
  localparam logic [7:0] OP_WD = 8'hDC;
  localparam logic [7:0] KnownOps [26] = '{
    OP_ADD, OP_AND, OP_COMP, OP_DIV, OP_J, OP_JEQ, OP_JGT, OP_JLT, OP_JSUB,
    OP_LDA, OP_LDCH, OP_LDL, OP_LDX, OP_MUL, OP_OR, OP_RD, OP_RSUB, OP_STA,
    OP_STCH, OP_STL, OP_STSW, OP_STX, OP_SUB, OP_TD, OP_TIX, OP_WD};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic result_valid;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  sic_instruction_executor dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow machine state
  logic [7:0] mem_img [MemBytes];
  bit written [MemBytes];
  logic [23:0] acc_m, ix_m, link_m, pc_m;
  logic [1:0] sw_m;
  bit run_m;
  logic [14:0] base_m;

  out_item_t pending_results [$];
  out_item_t want;
  int mismatches = 0;
  int steps_sent = 0;
  int faults_seen = 0;
  int phases_run = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  function automatic bit map_addr(input logic [23:0] a, input int n, output int idx);
    int off;
    idx = 0;
    if (a < {9'd0, base_m}) return 1'b0;
    off = int'(a) - int'(base_m);
    if (off > MemBytes - n) return 1'b0;
    idx = off;
    return 1'b1;
  endfunction

  function automatic logic [1:0] signed_cmp(input logic [23:0] a, input logic [23:0] b);
    if ($signed(a) > $signed(b)) return CC_GT;
    if ($signed(a) < $signed(b)) return CC_LT;
    return CC_EQ;
  endfunction

  function automatic void put_word(input int i, input logic [23:0] w);
    mem_img[i] = w[23:16];
    mem_img[i + 1] = w[15:8];
    mem_img[i + 2] = w[7:0];
    written[i] = 1'b1;
    written[i + 1] = 1'b1;
    written[i + 2] = 1'b1;
  endfunction

  // one instruction; returns 0 when it would read a byte never written
  function automatic bit run_instruction(input bit dry, output logic [1:0] flt);
    int fi, oi, sa, sb, q;
    logic [7:0] opc;
    logic [15:0] opnd;
    logic [23:0] ta, npc, v;
    logic [47:0] prod;
    bit rd_word, rd_byte, st_word;
    flt = FAULT_NONE;
    v = '0;
    rd_word = 1'b0;
    rd_byte = 1'b0;
    st_word = 1'b0;
    oi = 0;
    if (!map_addr(pc_m, 3, fi)) begin
      flt = FAULT_ADDR;
      return 1'b1;
    end
    if (!(written[fi] && written[fi + 1] && written[fi + 2])) return 1'b0;
    opc = mem_img[fi];
    opnd = {mem_img[fi + 1], mem_img[fi + 2]};
    ta = {9'd0, opnd[14:0]};
    if (opnd[15]) ta = ta + ix_m;
    npc = pc_m + 24'd3;
    case (opc)
      OP_ADD, OP_AND, OP_COMP, OP_DIV, OP_LDA, OP_LDL, OP_LDX, OP_MUL, OP_OR,
      OP_SUB, OP_TIX: rd_word = 1'b1;
      OP_LDCH, OP_STCH: rd_byte = 1'b1;
      OP_STA, OP_STL, OP_STSW, OP_STX: st_word = 1'b1;
      default: ;
    endcase
    if (rd_word || st_word) begin
      if (!map_addr(ta, 3, oi)) begin
        flt = FAULT_ADDR;
        return 1'b1;
      end
    end else if (rd_byte) begin
      if (!map_addr(ta, 1, oi)) begin
        flt = FAULT_ADDR;
        return 1'b1;
      end
    end
    if (rd_word) begin
      if (!(written[oi] && written[oi + 1] && written[oi + 2])) return 1'b0;
      v = {mem_img[oi], mem_img[oi + 1], mem_img[oi + 2]};
    end else if (rd_byte) begin
      if (!written[oi]) return 1'b0;
      v = {16'd0, mem_img[oi]};
    end
    if (opc == OP_DIV && v == '0) begin
      flt = FAULT_DIV0;
      return 1'b1;
    end
    if (dry) return 1'b1;
    pc_m = npc;
    case (opc)
      OP_ADD: acc_m = acc_m + v;
      OP_AND: acc_m = acc_m & v;
      OP_COMP: sw_m = signed_cmp(acc_m, v);
      OP_DIV: begin
        sa = $signed(acc_m);
        sb = $signed(v);
        q = sa / sb;
        acc_m = q[23:0];
      end
      OP_J: pc_m = ta;
      OP_JEQ: if (sw_m == CC_EQ) pc_m = ta;
      OP_JGT: if (sw_m == CC_GT) pc_m = ta;
      OP_JLT: if (sw_m == CC_LT) pc_m = ta;
      OP_JSUB: begin
        link_m = npc;
        pc_m = ta;
      end
      OP_LDA: acc_m = v;
      OP_LDCH: acc_m = {acc_m[23:8], v[7:0]};
      OP_LDL: link_m = v;
      OP_LDX: ix_m = v;
      OP_MUL: begin
        prod = {24'd0, acc_m} * {24'd0, v};
        acc_m = prod[23:0];
      end
      OP_OR: acc_m = acc_m | v;
      OP_RSUB: begin
        if (link_m == '0) run_m = 1'b0;
        else pc_m = link_m;
      end
      OP_STA: put_word(oi, acc_m);
      OP_STCH: begin
        mem_img[oi] = acc_m[7:0];
        written[oi] = 1'b1;
      end
      OP_STL: put_word(oi, link_m);
      OP_STSW: put_word(oi, {22'd0, sw_m});
      OP_STX: put_word(oi, ix_m);
      OP_SUB: acc_m = acc_m - v;
      OP_TD: sw_m = CC_GT;
      OP_TIX: begin
        ix_m = ix_m + 24'd1;
        sw_m = signed_cmp(ix_m, v);
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic bit step_is_safe();
    logic [1:0] flt;
    if (!run_m) return 1'b1;
    return run_instruction(1'b1, flt);
  endfunction

  // expected registers after one item
  function automatic out_item_t machine_after(input in_item_t it);
    out_item_t r;
    logic [1:0] flt;
    int idx;
    flt = FAULT_NONE;
    case (it.cmd)
      CMD_WRITE: begin
        if (map_addr({9'd0, it.address}, 1, idx)) begin
          mem_img[idx] = it.data_byte;
          written[idx] = 1'b1;
        end else begin
          flt = FAULT_ADDR;
        end
      end
      CMD_START: begin
        acc_m = '0;
        ix_m = '0;
        link_m = '0;
        sw_m = CC_NONE;
        pc_m = {9'd0, it.address};
        run_m = 1'b1;
      end
      CMD_STEP: if (run_m) void'(run_instruction(1'b0, flt));
      default: ;
    endcase
    r.pc = pc_m;
    r.acc = acc_m;
    r.index_reg = ix_m;
    r.link_reg = link_m;
    r.cond_code = sw_m;
    r.halted = !run_m;
    r.fault = flt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] exp_v);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, exp_v);
    mismatches++;
  endtask

  // send one item, predict at acceptance, maybe idle afterwards
  task automatic send_item(input in_item_t it);
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    want = machine_after(it);
    pending_results.push_back(want);
    if (it.cmd == CMD_STEP) steps_sent++;
    if (want.fault != FAULT_NONE) faults_seen++;
    if (!calm && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [1:0] c, input logic [14:0] a, input logic [7:0] d);
    in_item_t it;
    it.cmd = c;
    it.address = a;
    it.data_byte = d;
    send_item(it);
  endtask

  task automatic load_word(input logic [14:0] a, input logic [23:0] w);
    send_cmd(CMD_WRITE, a, w[23:16]);
    send_cmd(CMD_WRITE, a + 15'd1, w[15:8]);
    send_cmd(CMD_WRITE, a + 15'd2, w[7:0]);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_load_base(input logic [14:0] b);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_m = b;
  endtask

  // result check
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result.pc, '0);
      end else begin
        want = pending_results.pop_front();
        if (result.pc !== want.pc) report_mismatch("pc", result.pc, want.pc);
        if (result.acc !== want.acc) report_mismatch("acc", result.acc, want.acc);
        if (result.index_reg !== want.index_reg)
          report_mismatch("index_reg", result.index_reg, want.index_reg);
        if (result.link_reg !== want.link_reg)
          report_mismatch("link_reg", result.link_reg, want.link_reg);
        if (result.cond_code !== want.cond_code)
          report_mismatch("cond_code", 24'(result.cond_code), 24'(want.cond_code));
        if (result.halted !== want.halted)
          report_mismatch("halted", 24'(result.halted), 24'(want.halted));
        if (result.fault !== want.fault)
          report_mismatch("fault", 24'(result.fault), 24'(want.fault));
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // corner items: ignored command, idle step, range edges
  task automatic test_corners();
    set_load_base(15'd0);
    send_cmd(CMD_IGNORED, 15'h7FFF, 8'hFF);
    send_cmd(CMD_STEP, 15'd0, 8'd0);
    send_cmd(CMD_WRITE, 15'd0, 8'h00);
    send_cmd(CMD_WRITE, 15'(MemBytes - 1), 8'hFF);
    send_cmd(CMD_WRITE, 15'(MemBytes), 8'hAA);
    send_cmd(CMD_WRITE, 15'h7FFF, 8'h55);
    send_cmd(CMD_START, 15'h7FFF, 8'd0);
    send_cmd(CMD_STEP, 15'd0, 8'd0);
  endtask

  // overflowing divide, divide by zero, test device, return with zero link
  task automatic test_short_program();
    load_word(15'h30, 24'h800000);
    load_word(15'h33, 24'hFFFFFF);
    load_word(15'h36, 24'h000000);
    load_word(15'h00, {OP_LDA, 16'h0030});
    load_word(15'h03, {OP_DIV, 16'h0033});
    load_word(15'h06, {OP_DIV, 16'h0036});
    send_cmd(CMD_START, 15'd0, 8'd0);
    repeat (3) send_cmd(CMD_STEP, 15'd0, 8'd0);
    load_word(15'h06, {OP_TD, 16'h0000});
    load_word(15'h09, {OP_RSUB, 16'h0000});
    repeat (3) send_cmd(CMD_STEP, 15'd0, 8'd0);
  endtask

  function automatic logic [23:0] random_word(input int loc);
    int r;
    logic [7:0] opc;
    logic [23:0] t;
    logic [15:0] opnd;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return 24'($urandom_range(0, 40));
        2: return 24'($urandom());
        default: return {1'b1, 23'($urandom())};
      endcase
    end
    opc = (r < 85) ? KnownOps[$urandom_range(0, 25)] : 8'($urandom());
    t = 24'(loc + $urandom_range(0, WinBytes - 3));
    opnd = {1'b0, t[14:0]};
    if ($urandom_range(0, 4) == 0) opnd[15] = 1'b1;
    if ($urandom_range(0, 9) == 0) opnd = 16'($urandom());
    return {opc, opnd};
  endfunction

  // load a small program window, then run it with restarts and some noise
  task automatic test_program_phase(input logic [14:0] b);
    int span, wb, loc;
    logic [14:0] entry;
    in_item_t it;
    set_load_base(b);
    phases_run++;
    span = 32768 - int'(b) - WinBytes;
    wb = (span < 0) ? 0 : $urandom_range(0, (span > MemBytes - WinBytes) ?
                                          MemBytes - WinBytes : span);
    loc = int'(b) + wb;
    entry = 15'(loc);
    for (int g = 0; g < WinBytes / 3; g++) load_word(15'(loc + 3 * g), random_word(loc));
    send_cmd(CMD_START, entry, 8'd0);
    repeat (70) begin
      if ($urandom_range(0, 99) < 8) begin
        it = in_item_t'(25'($urandom()));
        if (it.cmd == CMD_STEP && !step_is_safe()) it.cmd = CMD_IGNORED;
        send_item(it);
      end else if (step_is_safe() && (run_m || $urandom_range(0, 9) < 4)) begin
        send_cmd(CMD_STEP, 15'($urandom()), 8'($urandom()));
      end else if ($urandom_range(0, 99) < 85) begin
        send_cmd(CMD_START, entry, 8'($urandom()));
      end else begin
        send_cmd(CMD_START, 15'($urandom()), 8'($urandom()));
      end
    end
  endtask

  task automatic test_random_programs();
    logic [14:0] b;
    for (int p = 0; p < 17; p++) begin
      calm = (p >= 4 && p < 7);
      case (p)
        0: b = 15'd0;
        1: b = 15'h7FFF;
        2: b = 15'(32768 - MemBytes);
        default: b = ($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 512))
                                                 : 15'($urandom());
      endcase
      test_program_phase(b);
    end
    calm = 1'b0;
  endtask

  initial begin
    acc_m = '0;
    ix_m = '0;
    link_m = '0;
    pc_m = '0;
    sw_m = CC_NONE;
    run_m = 1'b0;
    base_m = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_corners();
    test_short_program();
    test_random_programs();
    drain_results();
    if (pending_results.size() != 0) report_mismatch("results never arrived", '0, '0);
    $display("covered %0d program phases, %0d step items, %0d faulting items",
             phases_run, steps_sent, faults_seen);
    $display("load base swept from 0 to 32767, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
